FILE: rtl/gbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, constants and GF(2^8) arithmetic for the branch number block.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Field reduction polynomial x^8+x^4+x^3+x^2+1, low byte only
  localparam logic [7:0] GfPolyLow  = 8'h1D;
  // Starting value of the running minimum weight
  localparam logic [3:0] WeightInit = 4'd8;
  localparam int unsigned ElemW     = 8;
  localparam int unsigned WeightW   = 4;
  localparam int unsigned CfgW      = 64;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_ROWS_LOW  = 1'b0,
    CFG_ROWS_HIGH = 1'b1
  } cfg_idx_e;

  // One input transfer
  typedef struct packed {
    logic [ElemW-1:0] vec_elem0;
    logic [ElemW-1:0] vec_elem1;
    logic [ElemW-1:0] vec_elem2;
    logic [ElemW-1:0] vec_elem3;
    logic             restart;
  } in_t;

  // One result transfer
  typedef struct packed {
    logic [ElemW-1:0]   prod_elem0;
    logic [ElemW-1:0]   prod_elem1;
    logic [ElemW-1:0]   prod_elem2;
    logic [ElemW-1:0]   prod_elem3;
    logic [WeightW-1:0] weight;
    logic [WeightW-1:0] best_weight;
  } out_t;

  // Control from the datapath to the minimum tracker
  typedef struct packed {
    logic fire;
    logic restart;
    logic nonzero;
  } trk_ctrl_t;

  // GF(2^8) multiply: shift-and-add with reduction each step
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      sh = sh[7] ? ({sh[6:0], 1'b0} ^ GfPolyLow) : {sh[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

FILE: rtl/gbn_mat_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_mat_vec
// 4x4 matrix times 4-element vector over GF(2^8), one pass of logic.
// ----------------------------------------------------------------------------
module gbn_mat_vec (
  input  logic [gbn_pkg::CfgW-1:0]  rows_low_i,
  input  logic [gbn_pkg::CfgW-1:0]  rows_high_i,
  input  logic [3:0][7:0]           vec_i,
  output logic [3:0][7:0]           prod_o
);

  logic [1:0][gbn_pkg::CfgW-1:0] rows_word;

  assign rows_word[0] = rows_low_i;
  assign rows_word[1] = rows_high_i;

  // Form each product element as the XOR of four field products
  always_comb begin
    logic [7:0] acc;
    logic [7:0] coef;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        coef = rows_word[r / 2][8 * (4 * (r % 2) + c) +: 8];
        acc  = acc ^ gbn_pkg::gf_mul(coef, vec_i[c]);
      end
      prod_o[r] = acc;
    end
  end

endmodule

FILE: rtl/gbn_min_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_min_track
// Weight count of input and product, and the running minimum weight.
// ----------------------------------------------------------------------------
module gbn_min_track (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbn_pkg::trk_ctrl_t            ctrl_i,
  input  logic [3:0][7:0]               vec_i,
  input  logic [3:0][7:0]               prod_i,
  output logic [gbn_pkg::WeightW-1:0]   weight_o,
  output logic [gbn_pkg::WeightW-1:0]   best_o
);

  logic [gbn_pkg::WeightW-1:0] min_d, min_q;
  logic [gbn_pkg::WeightW-1:0] base;

  // Count nonzero bytes across both vectors
  always_comb begin
    weight_o = '0;
    for (int c = 0; c < 4; c++) begin
      weight_o = weight_o + {3'b000, |vec_i[c]} + {3'b000, |prod_i[c]};
    end
  end

  // Restart first, then fold in a nonzero vector's weight
  always_comb begin
    base  = ctrl_i.restart ? gbn_pkg::WeightInit : min_q;
    min_d = base;
    if (ctrl_i.nonzero && (weight_o < base)) begin
      min_d = weight_o;
    end
  end

  assign best_o = min_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= gbn_pkg::WeightInit;
    end else if (ctrl_i.fire) begin
      min_q <= min_d;
    end
  end

  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= gbn_pkg::WeightInit)
    else $error("running minimum above its start value");

  a_min_le_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.fire && ctrl_i.nonzero) |=> (min_q <= $past(weight_o)))
    else $error("minimum not updated by a smaller weight");

  a_min_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.fire |=> (min_q == $past(min_q)))
    else $error("minimum changed without a transfer");

endmodule

FILE: rtl/gf256_matrix_branch_number_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_matrix_branch_number_top
// Branch number search step: GF(2^8) 4x4 matrix product, weight, running min.
// ----------------------------------------------------------------------------
// The block takes one vector per clock cycle while the input is not stalled,
// and returns one result per vector, in order. An accepted vector sits in the
// input register, and its result is loaded into the output register once that
// register is empty or being drained; the result is taken from there when the
// output side does not stall. The input stalls only while both registers hold
// an item and the output side stalls. The clock period is set by the single
// pass through the sixteen GF(2^8) multipliers, the weight count and the
// minimum compare between those two registers. The matrix is written through
// the config port, rows 0-1 at index 0 and rows 2-3 at index 1; the user must
// write it only while no vector is in flight, as the block does not enforce it.
// restart resets the running minimum to 8 before its own vector is counted;
// all-zero vectors report their weight but never lower the minimum.
// ----------------------------------------------------------------------------
module gf256_matrix_branch_number_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  gbn_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [gbn_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gbn_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gbn_pkg::out_t               out_data_o
);

  logic [gbn_pkg::CfgW-1:0]    rows_low_q, rows_high_q;
  logic                        s1_valid_q;
  gbn_pkg::in_t                s1_data_q;
  logic                        out_valid_q;
  gbn_pkg::out_t               out_data_d, out_data_q;
  logic                        advance;
  logic                        in_fire;
  logic [3:0][7:0]             vec;
  logic [3:0][7:0]             prod;
  logic [gbn_pkg::WeightW-1:0] weight, best;
  gbn_pkg::trk_ctrl_t          trk_ctrl;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_low_q  <= '0;
      rows_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbn_pkg::CFG_ROWS_LOW:  rows_low_q  <= cfg_data_i;
        gbn_pkg::CFG_ROWS_HIGH: rows_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance into the output register when it is empty or being drained
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
  end

  assign vec[0] = s1_data_q.vec_elem0;
  assign vec[1] = s1_data_q.vec_elem1;
  assign vec[2] = s1_data_q.vec_elem2;
  assign vec[3] = s1_data_q.vec_elem3;

  gbn_mat_vec u_mat_vec (
    .rows_low_i  (rows_low_q),
    .rows_high_i (rows_high_q),
    .vec_i       (vec),
    .prod_o      (prod)
  );

  assign trk_ctrl.fire    = advance;
  assign trk_ctrl.restart = s1_data_q.restart;
  assign trk_ctrl.nonzero = |vec;

  gbn_min_track u_min_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (trk_ctrl),
    .vec_i    (vec),
    .prod_i   (prod),
    .weight_o (weight),
    .best_o   (best)
  );

  // Assemble the result
  always_comb begin
    out_data_d.prod_elem0  = prod[0];
    out_data_d.prod_elem1  = prod[1];
    out_data_d.prod_elem2  = prod[2];
    out_data_d.prod_elem3  = prod[3];
    out_data_d.weight      = weight;
    out_data_d.best_weight = best;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked item");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.weight <= 4'd8 && out_data_o.best_weight <= 4'd8))
    else $error("result weight out of range");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_o && out_data_o.best_weight == $past(best)))
    else $error("result register not loaded on advance");

endmodule
